[rtl/bstk_pkg.sv]
// Package: types, constants and field structs for the top-k keeper
`default_nettype none
package bstk_pkg;
  localparam int BEST_PER_SIZE = 8;
  localparam int MAX_SUBSET = 32;
  localparam int NSLOTS = 256;
  localparam int SLOT_W = 8;
  localparam int POS_W = (BEST_PER_SIZE > 1) ? $clog2(BEST_PER_SIZE) : 1;
  localparam int CRIT_W = 48;
  localparam logic [CRIT_W-1:0] CRIT_MAX = {CRIT_W{1'b1}};

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_DF = 2'd1;
  localparam logic [1:0] REG_SIGMA = 2'd2;
  localparam logic [1:0] REG_PEN = 2'd3;

  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_MS = 2'd1;
  localparam logic [1:0] MODE_PEN = 2'd2;

  localparam logic [1:0] ST_READ = 2'd0;
  localparam logic [1:0] ST_WORSE = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  typedef struct packed {
    logic        func;
    logic [47:0] rss;
    logic [5:0]  subset_size;
    logic [31:0] subset_label;
    logic [7:0]  read_slot;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  rank;
    logic [47:0] criterion;
    logic [31:0] read_label;
    logic        read_valid;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [47:0] rss;
    logic [5:0]  size;
    logic [1:0]  mode;
    logic [15:0] resid_df;
    logic [47:0] sigma_sq;
    logic [15:0] penalty;
  } crit_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] value;
  } crit_rsp_t;
endpackage
`default_nettype wire

[rtl/bstk_crit.sv]
// Criterion unit: serial divider for mode 1, staged multiply for mode 2, RSS passed through otherwise
`default_nettype none
module bstk_crit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  bstk_pkg::crit_req_t     req,
  output bstk_pkg::crit_rsp_t     rsp
);
  import bstk_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV = 3'd1;
  localparam logic [2:0] S_M1 = 3'd2;
  localparam logic [2:0] S_M2 = 3'd3;
  localparam logic [2:0] S_M3 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state;
  logic [5:0]  cnt;
  logic [47:0] quo;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [47:0] rss;
  logic [21:0] ps;
  logic [39:0] hi;
  logic [7:0]  lo;
  logic [41:0] p_hi_lo;
  logic [41:0] p_hi_hi;
  logic [29:0] p_lo;
  logic [63:0] acc;
  logic [47:0] value;
  logic        div_op;

  logic [16:0] rem_sh;
  logic [63:0] sum;
  logic [63:0] term;

  assign rem_sh = {rem[15:0], quo[47]};
  assign term = {2'd0, p_hi_hi, 20'd0} + {22'd0, p_hi_lo} + {42'd0, p_lo[29:8]};
  assign sum = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            rss <= req.rss;
            if (req.mode == MODE_MS) begin
              if ({10'd0, req.size} >= req.resid_df) begin
                value <= CRIT_MAX;
                state <= S_DONE;
              end else begin
                dvs <= req.resid_df - {10'd0, req.size};
                quo <= req.rss;
                rem <= '0;
                cnt <= 6'd0;
                div_op <= 1'b1;
                state <= S_DIV;
              end
            end else if (req.mode == MODE_PEN) begin
              ps <= 22'(req.penalty) * 22'(req.size);
              hi <= req.sigma_sq[47:8];
              lo <= req.sigma_sq[7:0];
              div_op <= 1'b0;
              state <= S_M1;
            end else begin
              value <= req.rss;
              state <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= rem_sh - {1'b0, dvs};
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[46:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) state <= S_M3;
        end
        S_M1: begin
          p_hi_lo <= ps * hi[19:0];
          p_hi_hi <= ps * hi[39:20];
          p_lo <= ps * lo;
          state <= S_M2;
        end
        S_M2: begin
          acc <= term + {16'd0, rss};
          state <= S_M3;
        end
        S_M3: begin
          if (div_op) begin
            value <= quo;
          end else begin
            value <= (sum[63:48] != 16'd0) ? CRIT_MAX : sum[47:0];
          end
          cnt <= 6'd0;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (state == S_DONE);
  assign rsp.value = value;
endmodule
`default_nettype wire

[rtl/best_subset_topk_keeper.sv]
// Top level: best-k regression keeper over a 256-slot memory
// Sequence: a read returns the addressed slot from the registered memory; an offer first
//   computes its criterion (divider in mode 1, multiply in mode 2), then scans its group and
//   is rejected or inserted with one write per shifted entry. One transaction at a time.
// Reset: synchronous; a clearing pass sets every criterion to all ones and valid to zero,
//   during which no transaction is accepted.
`default_nettype none
module best_subset_topk_keeper (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  bstk_pkg::in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bstk_pkg::out_t         out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [47:0]       cfg_data
);
  import bstk_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDW = 4'd3;
  localparam logic [3:0] S_CRIT = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_SCANW = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [1:0]  criterion_mode;
  logic [15:0] resid_df;
  logic [47:0] sigma_sq;
  logic [15:0] penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      criterion_mode <= 2'd0;
      resid_df <= 16'd0;
      sigma_sq <= 48'd65536;
      penalty <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: criterion_mode <= cfg_data[1:0];
        REG_DF: resid_df <= cfg_data[15:0];
        REG_SIGMA: sigma_sq <= cfg_data;
        REG_PEN: penalty <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // memory: {valid, label, criterion}
  logic [80:0] mem [NSLOTS];
  logic [80:0] rdata;
  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] waddr;
  logic [80:0] wdata;
  logic        we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [3:0]  state;
  in_t         item;
  logic [47:0] tr;
  logic [SLOT_W-1:0] base;
  logic [POS_W:0] idx;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] wpos;
  logic        found_c;
  logic [POS_W-1:0] pos_c;
  logic        walk;
  logic [80:0] row [BEST_PER_SIZE];
  logic [SLOT_W:0] clr;
  out_t        res;
  crit_req_t   creq;
  crit_rsp_t   crsp;

  bstk_crit u_crit (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  always_comb begin
    creq.start = (state == S_IDLE) && in_valid && !in_data.func;
    creq.rss = in_data.rss;
    creq.size = in_data.subset_size;
    creq.mode = criterion_mode;
    creq.resid_df = resid_df;
    creq.sigma_sq = sigma_sq;
    creq.penalty = penalty;
  end

  logic [5:0] gsz;
  logic [SLOT_W-1:0] base_c;
  always_comb begin
    gsz = in_data.subset_size;
    if (gsz == 6'd0) gsz = 6'd1;
    if (gsz > 6'(MAX_SUBSET)) gsz = 6'(MAX_SUBSET);
    base_c = (criterion_mode == MODE_MS || criterion_mode == MODE_PEN) ? '0 :
             SLOT_W'(gsz - 6'd1) * SLOT_W'(BEST_PER_SIZE);
  end

  // duplicate check and insert position over the scanned group
  always_comb begin
    found_c = 1'b0;
    pos_c = POS_W'(BEST_PER_SIZE - 1);
    walk = 1'b1;
    for (int m = 0; m < BEST_PER_SIZE; m++) begin
      if (row[m][80] && row[m][79:48] == item.subset_label) found_c = 1'b1;
    end
    for (int m = BEST_PER_SIZE - 1; m > 0; m--) begin
      if (walk && tr < row[m-1][47:0]) pos_c = POS_W'(m - 1);
      else walk = 1'b0;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    raddr = (state == S_IDLE) ? in_data.read_slot : base + SLOT_W'(idx);
    we = 1'b0;
    waddr = base + SLOT_W'(wpos);
    wdata = {1'b1, item.subset_label, tr};
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = clr[SLOT_W-1:0];
      wdata = {1'b0, 32'd0, CRIT_MAX};
    end else if (state == S_SHIFT) begin
      we = 1'b1;
      if (wpos != pos) wdata = row[wpos - 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (SLOT_W+1)'(NSLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            base <= base_c;
            idx <= '0;
            state <= in_data.func ? S_RDW : S_CRIT;
          end
        end
        S_RDW: begin
          res.status <= ST_READ;
          res.rank <= 4'd0;
          res.criterion <= rdata[47:0];
          res.read_label <= rdata[80] ? rdata[79:48] : 32'd0;
          res.read_valid <= rdata[80];
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_CRIT: begin
          if (crsp.done) begin
            tr <= crsp.value;
            state <= S_SCAN;
            idx <= idx + 1'b1;
          end
        end
        S_SCAN: begin
          row[idx[POS_W-1:0] - 1'b1] <= rdata;
          if (idx == (POS_W+1)'(BEST_PER_SIZE)) state <= S_SCANW;
          else idx <= idx + 1'b1;
        end
        S_SCANW: begin
          res.rank <= 4'd0;
          res.criterion <= tr;
          res.read_label <= 32'd0;
          res.read_valid <= 1'b0;
          if (!(row[BEST_PER_SIZE-1][47:0] > tr)) begin
            res.status <= ST_WORSE;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (found_c) begin
            res.status <= ST_DUP;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            pos <= pos_c;
            wpos <= POS_W'(BEST_PER_SIZE - 1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (wpos == pos) begin
            res.status <= ST_INS;
            res.rank <= 4'(pos);
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            wpos <= wpos - 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_data = res;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_shift_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && wpos == pos) |=> out_valid) else $error("shift did not finish");
`endif
endmodule
`default_nettype wire
